[src/edtr_pkg.sv]
// Shared types, constants and helpers for the edit-distance trie row unit.
package edtr_pkg;

   localparam int MAX_WORD_DEFAULT  = 16;
   localparam int MAX_DEPTH_DEFAULT = 32;
   localparam int CELL_W            = 6;
   localparam int CELL_MAX          = 63;
   localparam int LETTER_W          = 8;
   localparam int NUM_CHARS         = 16;
   localparam int DEPTH_W           = 5;
   localparam int LENGTH_W          = 5;
   localparam int COST_W            = 4;

   typedef enum logic [2:0] {
      REG_CHARS_LOW  = 3'd0,
      REG_CHARS_HIGH = 3'd1,
      REG_LENGTH     = 3'd2,
      REG_MAX_COST   = 3'd3,
      REG_TRANS_EN   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic load;
      logic run;
   } cell_ctl_type;

   function automatic logic [CELL_W-1:0] sat_cell(input logic [CELL_W:0] v);
      logic [CELL_W-1:0] r;
      if (v > (CELL_W + 1)'(CELL_MAX)) begin
         r = CELL_W'(CELL_MAX);
      end else begin
         r = v[CELL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [CELL_W-1:0] implicit_cell(input int k);
      logic [CELL_W-1:0] r;
      if (k > CELL_MAX) begin
         r = CELL_W'(CELL_MAX);
      end else begin
         r = CELL_W'(k);
      end
      return r;
   endfunction

endpackage

[src/edtr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module edtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/edtr_cell.sv]
// One column cell: local edit costs, insert ripple and running row minimum.
module edtr_cell (
   input  logic                              clock,
   input  edtr_pkg::cell_ctl_type            ctl,
   input  logic [edtr_pkg::CELL_W-1:0]       parent_here,
   input  logic [edtr_pkg::CELL_W-1:0]       parent_left,
   input  logic [edtr_pkg::CELL_W-1:0]       grand_diag,
   input  logic [edtr_pkg::LETTER_W-1:0]     char_here,
   input  logic [edtr_pkg::LETTER_W-1:0]     char_diag,
   input  logic [edtr_pkg::LETTER_W-1:0]     letter,
   input  logic [edtr_pkg::LETTER_W-1:0]     prev_letter,
   input  logic                              trans_ok,
   input  logic [edtr_pkg::CELL_W-1:0]       cur_left,
   input  logic [edtr_pkg::CELL_W-1:0]       mn_left,
   output logic [edtr_pkg::CELL_W-1:0]       cur,
   output logic [edtr_pkg::CELL_W-1:0]       mn,
   output logic                              changed
);

   logic [edtr_pkg::CELL_W-1:0] cur_ff, cur_in;
   logic [edtr_pkg::CELL_W-1:0] mn_ff, mn_in;
   logic [edtr_pkg::CELL_W:0]   del_cand, sub_cand, tr_cand, best;
   logic [edtr_pkg::CELL_W-1:0] start_val, ins_val, ripple_cur, ripple_mn;

   always_comb begin
      del_cand = {1'b0, parent_here} + (edtr_pkg::CELL_W + 1)'(1);
      sub_cand = {1'b0, parent_left} +
                 ((char_here != letter) ? (edtr_pkg::CELL_W + 1)'(1)
                                        : (edtr_pkg::CELL_W + 1)'(0));
      if (trans_ok && (char_here == prev_letter) && (char_diag == letter)) begin
         tr_cand = {1'b0, grand_diag} + (edtr_pkg::CELL_W + 1)'(1);
      end else begin
         tr_cand = '1;
      end
      best = (del_cand < sub_cand) ? del_cand : sub_cand;
      best = (tr_cand < best) ? tr_cand : best;
      start_val = edtr_pkg::sat_cell(best);

      ins_val    = edtr_pkg::sat_cell({1'b0, cur_left} + (edtr_pkg::CELL_W + 1)'(1));
      ripple_cur = (ins_val < cur_ff) ? ins_val : cur_ff;
      ripple_mn  = (mn_left < cur_ff) ? mn_left : cur_ff;
      changed    = (ripple_cur != cur_ff) || (ripple_mn != mn_ff);

      if (ctl.load) begin
         cur_in = start_val;
         mn_in  = edtr_pkg::CELL_W'(edtr_pkg::CELL_MAX);
      end else if (ctl.run) begin
         cur_in = ripple_cur;
         mn_in  = ripple_mn;
      end else begin
         cur_in = cur_ff;
         mn_in  = mn_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      mn_ff  <= mn_in;
   end

   assign cur = cur_ff;
   assign mn  = mn_ff;

endmodule

[src/edit_distance_trie_row_step.sv]
// Top level of the edit-distance trie row unit: register port, row stacks, cell row.
//
//   Channel   Direction  Handshake                 Payload
//   req       in         req_valid / req_ready     req_depth, req_letter
//   rsp       out        rsp_valid / rsp_ready     rsp_distance, rsp_row_min, flags
//   csr       in/out     psel, penable, pwrite     paddr, pwdata, prdata
//
// An accepted item moves through the load, run and done states; the done state waits
// for the output register to be free, and the input is ready again once the result is
// loaded. The cells ripple insert costs and the row minimum one column per cycle, and
// the last run cycle is the first with no change. One item is in work at a time.
// The row stacks hold undefined data after reset; no clearing pass is needed.
// A stalled result sits in the output register while the next word is accepted.
module edit_distance_trie_row_step #(
   parameter int MAX_WORD  = edtr_pkg::MAX_WORD_DEFAULT,
   parameter int MAX_DEPTH = edtr_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [edtr_pkg::DEPTH_W-1:0]        req_depth,
   input  logic [edtr_pkg::LETTER_W-1:0]       req_letter,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [edtr_pkg::CELL_W-1:0]         rsp_distance,
   output logic [edtr_pkg::CELL_W-1:0]         rsp_row_min,
   output logic                                rsp_match_within,
   output logic                                rsp_descend_ok,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [5:0]                          paddr,
   input  logic [63:0]                         pwdata,
   output logic [63:0]                         prdata,
   output logic                                pready
);

   localparam int COLS  = MAX_WORD + 1;
   localparam int ROW_W = COLS * edtr_pkg::CELL_W;
   localparam int AW    = $clog2(MAX_DEPTH);
   localparam int DW    = ((AW > edtr_pkg::DEPTH_W) ? AW : edtr_pkg::DEPTH_W) + 1;
   localparam int NW    = $clog2(COLS);
   localparam int LW    = ((NW > edtr_pkg::LENGTH_W) ? NW : edtr_pkg::LENGTH_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [63:0]                       chars_low_ff, chars_high_ff;
   logic [edtr_pkg::LENGTH_W-1:0]     length_ff;
   logic [edtr_pkg::COST_W-1:0]       max_cost_ff;
   logic                              trans_en_ff;

   logic [AW-1:0]                     depth_ff, depth_clamped;
   logic [DW-1:0]                     depth_wide;
   logic [edtr_pkg::LETTER_W-1:0]     letter_ff;

   logic                              rsp_valid_ff, rsp_match_ff, rsp_descend_ff;
   logic [edtr_pkg::CELL_W-1:0]       rsp_distance_ff, rsp_row_min_ff;

   logic                              csr_write;
   logic                              accept;
   logic                              row_we, any_changed, out_free;
   logic                              depth_is0, depth_is1, trans_active;
   logic [AW-1:0]                     raddr_parent, raddr_grand;
   logic [ROW_W+edtr_pkg::LETTER_W-1:0] rdata_parent, wdata_parent;
   logic [ROW_W-1:0]                  rdata_grand, row_packed;
   logic [edtr_pkg::LETTER_W-1:0]     prev_letter;
   logic [127:0]                      chars_all;

   logic [edtr_pkg::CELL_W-1:0]       parent_row [COLS];
   logic [edtr_pkg::CELL_W-1:0]       grand_row  [COLS];
   logic [edtr_pkg::CELL_W-1:0]       cur_row    [COLS];
   logic [edtr_pkg::CELL_W-1:0]       mn_row     [COLS];
   logic [edtr_pkg::LETTER_W-1:0]     word_char  [MAX_WORD];
   logic [COLS-1:0]                   changed_vec;
   edtr_pkg::cell_ctl_type            cell_ctl;

   logic [LW-1:0]                     length_ext;
   logic [NW-1:0]                     n_sel;
   logic [edtr_pkg::CELL_W-1:0]       dist_sel, min_sel;

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
         length_ff     <= '0;
         max_cost_ff   <= '0;
         trans_en_ff   <= 1'b1;
      end else if (csr_write) begin
         unique case (paddr[5:3])
            edtr_pkg::REG_CHARS_LOW:  chars_low_ff  <= pwdata;
            edtr_pkg::REG_CHARS_HIGH: chars_high_ff <= pwdata;
            edtr_pkg::REG_LENGTH:     length_ff     <= pwdata[edtr_pkg::LENGTH_W-1:0];
            edtr_pkg::REG_MAX_COST:   max_cost_ff   <= pwdata[edtr_pkg::COST_W-1:0];
            edtr_pkg::REG_TRANS_EN:   trans_en_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         edtr_pkg::REG_CHARS_LOW:  prdata = chars_low_ff;
         edtr_pkg::REG_CHARS_HIGH: prdata = chars_high_ff;
         edtr_pkg::REG_LENGTH:     prdata = 64'(length_ff);
         edtr_pkg::REG_MAX_COST:   prdata = 64'(max_cost_ff);
         edtr_pkg::REG_TRANS_EN:   prdata = 64'(trans_en_ff);
         default:                  prdata = '0;
      endcase
   end

   // Depth clamp and stack read addresses.
   assign req_ready  = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_valid && req_ready;
   assign depth_wide = DW'(req_depth);

   always_comb begin
      if (depth_wide >= DW'(MAX_DEPTH)) begin
         depth_clamped = AW'(MAX_DEPTH - 1);
      end else begin
         depth_clamped = depth_wide[AW-1:0];
      end
   end

   assign raddr_parent = depth_clamped - AW'(1);
   assign raddr_grand  = depth_clamped - AW'(2);

   edtr_ram #(
      .WIDTH (ROW_W + edtr_pkg::LETTER_W),
      .DEPTH (MAX_DEPTH)
   ) u_parent_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (depth_ff),
      .wdata (wdata_parent),
      .raddr (raddr_parent),
      .rdata (rdata_parent)
   );

   edtr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_DEPTH)
   ) u_grand_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (depth_ff),
      .wdata (row_packed),
      .raddr (raddr_grand),
      .rdata (rdata_grand)
   );

   assign wdata_parent = {letter_ff, row_packed};
   assign prev_letter  = rdata_parent[ROW_W +: edtr_pkg::LETTER_W];
   assign depth_is0    = (depth_ff == AW'(0));
   assign depth_is1    = (depth_ff == AW'(1));
   assign trans_active = trans_en_ff && !depth_is0;
   assign chars_all    = {chars_high_ff, chars_low_ff};

   assign cell_ctl.load = (state_ff == ST_LOAD);
   assign cell_ctl.run  = (state_ff == ST_RUN);
   assign any_changed   = |changed_vec;
   assign row_we        = (state_ff == ST_RUN) && !any_changed;

   for (genvar i = 0; i < MAX_WORD; i++) begin : g_char
      if (i < edtr_pkg::NUM_CHARS) begin : g_cfg
         assign word_char[i] = chars_all[i*edtr_pkg::LETTER_W +: edtr_pkg::LETTER_W];
      end else begin : g_zero
         assign word_char[i] = '0;
      end
   end

   // Row of column cells.
   for (genvar c = 0; c < COLS; c++) begin : g_col
      logic [edtr_pkg::CELL_W-1:0]   parent_left, grand_diag, cur_left, mn_left;
      logic [edtr_pkg::LETTER_W-1:0] char_here, char_diag;
      logic                          trans_ok;

      assign parent_row[c] = depth_is0 ? edtr_pkg::implicit_cell(c)
                                       : rdata_parent[c*edtr_pkg::CELL_W +: edtr_pkg::CELL_W];
      assign grand_row[c]  = depth_is1 ? edtr_pkg::implicit_cell(c)
                                       : rdata_grand[c*edtr_pkg::CELL_W +: edtr_pkg::CELL_W];
      assign row_packed[c*edtr_pkg::CELL_W +: edtr_pkg::CELL_W] = cur_row[c];

      if (c == 0) begin : g_first
         assign parent_left = edtr_pkg::CELL_W'(edtr_pkg::CELL_MAX);
         assign cur_left    = edtr_pkg::CELL_W'(edtr_pkg::CELL_MAX);
         assign mn_left     = edtr_pkg::CELL_W'(edtr_pkg::CELL_MAX);
         assign char_here   = '0;
      end else begin : g_rest
         assign parent_left = parent_row[c-1];
         assign cur_left    = cur_row[c-1];
         assign mn_left     = mn_row[c-1];
         assign char_here   = word_char[c-1];
      end

      if (c >= 2) begin : g_diag
         assign grand_diag = grand_row[c-2];
         assign char_diag  = word_char[c-2];
         assign trans_ok   = trans_active;
      end else begin : g_nodiag
         assign grand_diag = edtr_pkg::CELL_W'(edtr_pkg::CELL_MAX);
         assign char_diag  = '0;
         assign trans_ok   = 1'b0;
      end

      edtr_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .parent_here (parent_row[c]),
         .parent_left (parent_left),
         .grand_diag  (grand_diag),
         .char_here   (char_here),
         .char_diag   (char_diag),
         .letter      (letter_ff),
         .prev_letter (prev_letter),
         .trans_ok    (trans_ok),
         .cur_left    (cur_left),
         .mn_left     (mn_left),
         .cur         (cur_row[c]),
         .mn          (mn_row[c]),
         .changed     (changed_vec[c])
      );
   end

   // Result selection at the last column in use.
   assign length_ext = LW'(length_ff);

   always_comb begin
      if (length_ext > LW'(MAX_WORD)) begin
         n_sel = NW'(MAX_WORD);
      end else begin
         n_sel = length_ext[NW-1:0];
      end
   end

   assign dist_sel = cur_row[n_sel];
   assign min_sel  = mn_row[n_sel];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  depth_ff  <= depth_clamped;
                  letter_ff <= req_letter;
                  state_ff  <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (!any_changed) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_distance_ff <= dist_sel;
                  rsp_row_min_ff  <= min_sel;
                  rsp_match_ff    <= (dist_sel <= edtr_pkg::CELL_W'(max_cost_ff));
                  rsp_descend_ff  <= (min_sel <= edtr_pkg::CELL_W'(max_cost_ff));
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance     = rsp_distance_ff;
   assign rsp_row_min      = rsp_row_min_ff;
   assign rsp_match_within = rsp_match_ff;
   assign rsp_descend_ok   = rsp_descend_ff;

endmodule

[src/edtr_checker.sv]
// Port-level checker for the edit-distance trie row unit, bound to the top level.
module edtr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [edtr_pkg::CELL_W-1:0]   rsp_distance,
   input logic [edtr_pkg::CELL_W-1:0]   rsp_row_min,
   input logic                          rsp_match_within,
   input logic                          rsp_descend_ok
);

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
                                 && $stable(rsp_row_min))
      else $error("stalled result word changed");

   // The row minimum covers the last column, so it never exceeds the distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_min <= rsp_distance)
      else $error("row minimum above distance");

   // A match implies the row minimum is within the limit as well.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_within |-> rsp_descend_ok)
      else $error("match without descend");

   // No result word is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind edit_distance_trie_row_step edtr_checker u_edtr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_distance     (rsp_distance),
   .rsp_row_min      (rsp_row_min),
   .rsp_match_within (rsp_match_within),
   .rsp_descend_ok   (rsp_descend_ok)
);
